// ===== hw/rtl/qvb_pkg.sv =====
// ----------------------------------------------------------------------------
// qvb_pkg
// Shared constants, types and the quarter-wave sine table for the quad
// vertex batcher.
// ----------------------------------------------------------------------------
package qvb_pkg;

  localparam int MAX_QUADS       = 8192;
  localparam int SINE_TABLE_BITS = 10;
  localparam int TAB_N           = 1 << SINE_TABLE_BITS;
  localparam int ROM_AW          = SINE_TABLE_BITS + 1;

  // Command codes
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // Operand pairs for the shared multiplier
  localparam logic [1:0] MUL_CS_SX = 2'd0;
  localparam logic [1:0] MUL_SN_SY = 2'd1;
  localparam logic [1:0] MUL_SN_SX = 2'd2;
  localparam logic [1:0] MUL_CS_SY = 2'd3;

  typedef logic [16:0] sine_rom_t [0:TAB_N];

  // Taylor denominators (2k)(2k+1), k = 1..12
  localparam int TAYLOR_DEN [1:12] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};

  // Build the quarter-wave sine magnitudes, Q16, at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic signed [63:0] s;
    for (int i = 0; i <= TAB_N; i++) begin
      x  = (64'd1686629713 * 64'(i)) >> SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      t  = x;
      s  = $signed(x);
      for (int k = 1; k <= 12; k++) begin
        t = ((t * x2) >> 30) / 64'(TAYLOR_DEN[k]);
        if (k % 2 == 1) s = s - $signed(t);
        else            s = s + $signed(t);
      end
      if (s < 0) s = 64'sd0;
      rom[i] = 17'((64'(s) + 64'd8192) >> 14);
    end
    rom[TAB_N] = 17'd65536;
    return rom;
  endfunction

  // Controller to datapath commands
  typedef struct packed {
    logic        capture;
    logic        rom_rd;
    logic        mul_en;
    logic [1:0]  mul_sel;
    logic        load_vert;
    logic        load_flush;
    logic [1:0]  corner;
    logic        flush;
    logic [15:0] indices;
  } qvb_cmd_t;

endpackage

// ===== hw/rtl/qvb_ctrl.sv =====
// ----------------------------------------------------------------------------
// qvb_ctrl
// Sequencer for the batcher: handshakes, batch quad count, flush tracking.
// ----------------------------------------------------------------------------
module qvb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      cmd,
  output logic            out_valid,
  input  logic            out_stall,
  output qvb_pkg::qvb_cmd_t dp_cmd
);
  import qvb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROM  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;

  logic [2:0]  state, state_next;
  logic [1:0]  cnt, cnt_next;
  logic [13:0] quad_count, quad_count_next;
  logic        flush_pend, flush_pend_next;
  logic [15:0] flush_idx, flush_idx_next;
  logic        in_acc, can_load, load;
  logic [15:0] count_x6;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign can_load = !out_valid || !out_stall;
  assign count_x6 = {quad_count, 2'b00} + {1'b0, quad_count, 1'b0};
  assign load     = dp_cmd.load_vert || dp_cmd.load_flush;

  // Sequence one command
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    quad_count_next = quad_count;
    flush_pend_next = flush_pend;
    flush_idx_next  = flush_idx;
    dp_cmd          = '0;
    dp_cmd.mul_sel  = cnt;
    dp_cmd.corner   = cnt;
    dp_cmd.flush    = flush_pend && (cnt == 2'd0);
    dp_cmd.indices  = (cnt == 2'd0) ? flush_idx : 16'd0;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_BEGIN: quad_count_next = '0;
            CMD_DRAW: begin
              dp_cmd.capture = 1'b1;
              if (quad_count >= 14'(MAX_QUADS)) begin
                flush_pend_next = 1'b1;
                flush_idx_next  = count_x6;
                quad_count_next = 14'd1;
              end else begin
                flush_pend_next = 1'b0;
                flush_idx_next  = '0;
                quad_count_next = quad_count + 14'd1;
              end
              state_next = S_ROM;
            end
            CMD_END: state_next = S_END;
            default: ;
          endcase
        end
      end
      S_ROM: begin
        dp_cmd.rom_rd = 1'b1;
        cnt_next      = '0;
        state_next    = S_MUL;
      end
      S_MUL: begin
        dp_cmd.mul_en = 1'b1;
        cnt_next      = cnt + 2'd1;
        if (cnt == 2'd3) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (can_load) begin
          dp_cmd.load_vert = 1'b1;
          cnt_next         = cnt + 2'd1;
          if (cnt == 2'd3) state_next = S_IDLE;
        end
      end
      S_END: begin
        dp_cmd.indices = count_x6;
        if (can_load) begin
          dp_cmd.load_flush = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance state and hold the output beat flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      quad_count <= '0;
      flush_pend <= 1'b0;
      flush_idx  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      quad_count <= quad_count_next;
      flush_pend <= flush_pend_next;
      flush_idx  <= flush_idx_next;
      if (load)           out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    quad_count <= 14'(MAX_QUADS)) else $error("quad count above batch size");
  a_flush_corner0: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.load_vert && dp_cmd.flush |-> dp_cmd.corner == 2'd0)
    else $error("flush on a later corner");
  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && dp_cmd.load_vert && cnt == 2'd3 |=> state == S_IDLE)
    else $error("no return to idle after last corner");

endmodule

// ===== hw/rtl/qvb_dp.sv =====
// ----------------------------------------------------------------------------
// qvb_dp
// Datapath: operand capture, sine ROM, shared multiplier, corner combine,
// rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module qvb_dp (
  input  logic                 clk,
  input  qvb_pkg::qvb_cmd_t    dp_cmd,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   pos_z,
  input  logic signed [31:0]   scale_x,
  input  logic signed [31:0]   scale_y,
  input  logic [15:0]          angle,
  input  logic [7:0]           red_in,
  input  logic [7:0]           green_in,
  input  logic [7:0]           blue_in,
  input  logic [7:0]           alpha_in,
  output logic signed [31:0]   vert_x,
  output logic signed [31:0]   vert_y,
  output logic signed [31:0]   vert_z,
  output logic [7:0]           red_out,
  output logic [7:0]           green_out,
  output logic [7:0]           blue_out,
  output logic [7:0]           alpha_out,
  output logic [1:0]           corner,
  output logic                 flush_before,
  output logic [15:0]          flush_indices,
  output logic                 is_vertex,
  output logic                 last
);
  import qvb_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic signed [31:0] px, py, pz, sx, sy;
  logic [15:0]        ang;
  logic [7:0]         cr, cg, cb, ca;
  logic [16:0]        rom_a, rom_b;
  logic [1:0]         quad;
  logic [ROM_AW-1:0]  idx_a, idx_b;
  logic signed [17:0] sn, cs, mul_a;
  logic signed [31:0] mul_b;
  logic signed [49:0] prod [4];
  logic signed [51:0] ex, ey;
  logic signed [35:0] rx, ry;
  logic signed [36:0] sum_x, sum_y;
  logic               neg_x, neg_y;

  // Capture the command operands
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      px <= pos_x;  py <= pos_y;  pz <= pos_z;
      sx <= scale_x; sy <= scale_y; ang <= angle;
      cr <= red_in; cg <= green_in; cb <= blue_in; ca <= alpha_in;
    end
  end

  // Read sine at the angle and its complement
  assign idx_a = {1'b0, ang[13:14-SINE_TABLE_BITS]};
  assign idx_b = ROM_AW'(TAB_N) - idx_a;
  always_ff @(posedge clk) begin
    if (dp_cmd.rom_rd) begin
      rom_a <= SINE_ROM[idx_a];
      rom_b <= SINE_ROM[idx_b];
      quad  <= ang[15:14];
    end
  end

  // Fold the quadrant into signed sine and cosine
  always_comb begin
    case (quad)
      2'd0:    begin sn =  $signed({1'b0, rom_a}); cs =  $signed({1'b0, rom_b}); end
      2'd1:    begin sn =  $signed({1'b0, rom_b}); cs = -$signed({1'b0, rom_a}); end
      2'd2:    begin sn = -$signed({1'b0, rom_a}); cs = -$signed({1'b0, rom_b}); end
      default: begin sn = -$signed({1'b0, rom_b}); cs =  $signed({1'b0, rom_a}); end
    endcase
  end

  // One product per cycle through the shared multiplier
  always_comb begin
    case (dp_cmd.mul_sel)
      MUL_CS_SX: begin mul_a = cs; mul_b = sx; end
      MUL_SN_SY: begin mul_a = sn; mul_b = sy; end
      MUL_SN_SX: begin mul_a = sn; mul_b = sx; end
      default:   begin mul_a = cs; mul_b = sy; end
    endcase
  end
  always_ff @(posedge clk) begin
    if (dp_cmd.mul_en) prod[dp_cmd.mul_sel] <= 50'(mul_a * mul_b);
  end

  // Combine products for this corner, round, translate, saturate
  assign neg_x = (dp_cmd.corner == 2'd0) || (dp_cmd.corner == 2'd1);
  assign neg_y = (dp_cmd.corner == 2'd0) || (dp_cmd.corner == 2'd3);
  always_comb begin
    ex = (neg_x ? -52'(prod[MUL_CS_SX]) : 52'(prod[MUL_CS_SX]))
       - (neg_y ? -52'(prod[MUL_SN_SY]) : 52'(prod[MUL_SN_SY]));
    ey = (neg_x ? -52'(prod[MUL_SN_SX]) : 52'(prod[MUL_SN_SX]))
       + (neg_y ? -52'(prod[MUL_CS_SY]) : 52'(prod[MUL_CS_SY]));
    rx = 36'((ex + 52'sd32768) >>> 16);
    ry = 36'((ey + 52'sd32768) >>> 16);
    sum_x = 37'(rx) + 37'(px);
    sum_y = 37'(ry) + 37'(py);
  end

  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sh07FFFFFFF)       return 32'h7FFFFFFF;
    else if (v < -37'sh080000000) return 32'h80000000;
    else                          return v[31:0];
  endfunction

  // Load the output beat
  always_ff @(posedge clk) begin
    if (dp_cmd.load_vert) begin
      vert_x        <= sat32(sum_x);
      vert_y        <= sat32(sum_y);
      vert_z        <= pz;
      red_out       <= cr;  green_out <= cg;  blue_out <= cb;  alpha_out <= ca;
      corner        <= dp_cmd.corner;
      flush_before  <= dp_cmd.flush;
      flush_indices <= dp_cmd.flush ? dp_cmd.indices : 16'd0;
      is_vertex     <= 1'b1;
      last          <= (dp_cmd.corner == 2'd3);
    end else if (dp_cmd.load_flush) begin
      vert_x        <= '0;  vert_y <= '0;  vert_z <= '0;
      red_out       <= '0;  green_out <= '0;  blue_out <= '0;  alpha_out <= '0;
      corner        <= '0;
      flush_before  <= 1'b1;
      flush_indices <= dp_cmd.indices;
      is_vertex     <= 1'b0;
      last          <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/quad_vertex_batcher.sv =====
// ----------------------------------------------------------------------------
// quad_vertex_batcher
// Turns draw-quad commands into four transformed, colored vertices and
// tracks batch fill with flush markers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall   | cmd, pos, scale, angle, color
//  out     | output    | out_valid / out_stall | vertex, color, corner, flush info
//
//  A draw is captured on accept, then reads the sine ROM, forms four
//  products through the single shared multiplier, then loads one output
//  beat per corner, four beats per quad.
//  An end is accepted, then loads its one flush beat; begin and the
//  unused code finish at the accept.
//  Reset (rst, synchronous) clears the quad count and the sequencer.
//  Output stalls hold the beat and pause the sequencer before its next beat.
module quad_vertex_batcher (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic [15:0]        angle,
  input  logic [7:0]         red_in,
  input  logic [7:0]         green_in,
  input  logic [7:0]         blue_in,
  input  logic [7:0]         alpha_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] vert_x,
  output logic signed [31:0] vert_y,
  output logic signed [31:0] vert_z,
  output logic [7:0]         red_out,
  output logic [7:0]         green_out,
  output logic [7:0]         blue_out,
  output logic [7:0]         alpha_out,
  output logic [1:0]         corner,
  output logic               flush_before,
  output logic [15:0]        flush_indices,
  output logic               is_vertex,
  output logic               last
);
  import qvb_pkg::*;

  qvb_cmd_t dp_cmd;

  qvb_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .cmd, .out_valid, .out_stall, .dp_cmd
  );

  qvb_dp u_dp (
    .clk, .dp_cmd, .pos_x, .pos_y, .pos_z, .scale_x, .scale_y, .angle,
    .red_in, .green_in, .blue_in, .alpha_in,
    .vert_x, .vert_y, .vert_z, .red_out, .green_out, .blue_out, .alpha_out,
    .corner, .flush_before, .flush_indices, .is_vertex, .last
  );

endmodule
